// ===== src/ordered_shelf_list_engine_defines.svh =====
// Assertion macros shared by the shelf list engine.
`ifndef ORDERED_SHELF_LIST_ENGINE_DEFINES_SVH
`define ORDERED_SHELF_LIST_ENGINE_DEFINES_SVH

// Checks a consequence in the clock after the antecedent.
`define OSLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Checks a consequence in the same clock as the antecedent.
`define OSLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/osle_pkg.sv =====
`default_nettype none

package osle_pkg;

  // Command codes carried on cmd_i.
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_TOP    = 3'd1;
  localparam logic [2:0] CMD_BOTTOM = 3'd2;
  localparam logic [2:0] CMD_SWAP   = 3'd3;
  localparam logic [2:0] CMD_ASK    = 3'd4;
  localparam logic [2:0] CMD_QUERY  = 3'd5;

  // Swap direction codes.
  localparam logic [1:0] DIR_UP   = 2'b11;
  localparam logic [1:0] DIR_DOWN = 2'b01;

  // Reset value of the shelf count register.
  localparam logic [8:0] SHELF_RESET = 9'd256;

  // Source of the item memory read address.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_RANK,
    RD_POS,
    RD_CUR_NB,
    RD_NB_NB
  } rdsel_e;

  // Source of a result.
  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_ZERO,
    RESP_CUR,
    RESP_ITEM
  } resp_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   latch;
    logic   load;
    logic   pos_rd;
    logic   cur_load;
    logic   step_wr;
    logic   final_wr;
    logic   up;
    rdsel_e rd_sel;
    resp_e  resp;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_ok;
    logic rank_ok;
    logic found;
    logic cur_edge;
    logic nb_edge;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/osle_ctrl.sv =====
`default_nettype none

module osle_ctrl
  import osle_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  input  wire  [2:0] cmd_i,
  input  wire  [1:0] direction_i,
  input  stat_t      stat_i,
  output ctl_t       ctl_o,
  output logic       busy_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FPOS  = 6'b000010,
    S_FITEM = 6'b000100,
    S_STEP  = 6'b001000,
    S_FINAL = 6'b010000,
    S_QRD   = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cmd_q;
  logic [1:0] dir_q;
  logic       up;
  logic       dir_valid;

  // State and the command of the transaction in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_LOAD;
      dir_q   <= 2'b00;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start) begin
        cmd_q <= cmd_i;
        dir_q <= direction_i;
      end
    end
  end

  // Moves toward the top walk upward; everything else walks downward.
  assign up        = (cmd_q == CMD_TOP) || (cmd_q == CMD_SWAP && dir_q == DIR_UP);
  assign dir_valid = (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
  assign busy_o    = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d      = state_q;
    ctl_o        = '0;
    ctl_o.rd_sel = RD_NONE;
    ctl_o.resp   = RESP_NONE;
    ctl_o.up     = up;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.latch = 1'b1;
          unique case (cmd_i)
            CMD_LOAD: ctl_o.load = 1'b1;
            CMD_TOP, CMD_BOTTOM, CMD_SWAP: begin
              if (stat_i.id_ok) begin
                ctl_o.pos_rd = 1'b1;
                state_d      = S_FPOS;
              end
            end
            CMD_ASK: begin
              if (stat_i.id_ok) begin
                ctl_o.pos_rd = 1'b1;
                state_d      = S_FPOS;
              end else begin
                ctl_o.resp = RESP_ZERO;
              end
            end
            CMD_QUERY: begin
              if (stat_i.rank_ok) begin
                ctl_o.rd_sel = RD_RANK;
                state_d      = S_QRD;
              end else begin
                ctl_o.resp = RESP_ZERO;
              end
            end
            default: ;
          endcase
        end
      end
      S_FPOS: begin
        ctl_o.rd_sel   = RD_POS;
        ctl_o.cur_load = 1'b1;
        state_d        = S_FITEM;
      end
      S_FITEM: begin
        state_d = S_IDLE;
        if (cmd_q == CMD_ASK) begin
          ctl_o.resp = stat_i.found ? RESP_CUR : RESP_ZERO;
        end else if (stat_i.found) begin
          if (cmd_q == CMD_SWAP) begin
            if (dir_valid && !stat_i.cur_edge) begin
              ctl_o.rd_sel = RD_CUR_NB;
              state_d      = S_STEP;
            end
          end else if (stat_i.cur_edge) begin
            state_d = S_FINAL;
          end else begin
            ctl_o.rd_sel = RD_CUR_NB;
            state_d      = S_STEP;
          end
        end
      end
      S_STEP: begin
        ctl_o.step_wr = 1'b1;
        if (cmd_q == CMD_SWAP || stat_i.nb_edge) begin
          state_d = S_FINAL;
        end else begin
          ctl_o.rd_sel = RD_NB_NB;
        end
      end
      S_FINAL: begin
        ctl_o.final_wr = 1'b1;
        state_d        = S_IDLE;
      end
      S_QRD: begin
        ctl_o.resp = RESP_ITEM;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/osle_dpath.sv =====
`default_nettype none

module osle_dpath
  import osle_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [8:0] cfg_wdata_i,
  input  wire  [8:0] item_id_i,
  input  wire  [8:0] rank_i,
  input  ctl_t       ctl_i,
  output stat_t      stat_o,
  output logic       done_o,
  output logic [8:0] answer_o
);

  localparam int PW    = $clog2(MAX_ITEMS);
  localparam int LW    = PW + 1;
  localparam int CW    = (LW > 9) ? LW : 9;
  localparam int IDEP  = (MAX_ITEMS < 511) ? MAX_ITEMS + 1 : 512;
  localparam int IDX_W = $clog2(IDEP);

  // Item per position and position per id.
  logic [8:0]    item_mem [MAX_ITEMS];
  logic [PW-1:0] pos_mem  [IDEP];

  logic [8:0]       shelf_q;
  logic [LW-1:0]    lp_q;
  logic [8:0]       id_q;
  logic [PW-1:0]    cur_q;
  logic [PW-1:0]    pos_rdata_q;
  logic [8:0]       item_rdata_q;
  logic             done_q;
  logic [8:0]       answer_q;

  logic [PW-1:0]    nb, nb2, rd_addr, wr_addr;
  logic             rd_en, wr_en, load_fire;
  logic [8:0]       wr_data;
  logic [IDX_W-1:0] pwr_addr;
  logic [PW-1:0]    pwr_data;
  logic             pwr_en;

  // Neighbors one and two steps along the walk.
  assign nb  = ctl_i.up ? cur_q - PW'(1) : cur_q + PW'(1);
  assign nb2 = ctl_i.up ? nb - PW'(1) : nb + PW'(1);

  // Status toward the controller.
  assign stat_o.id_ok    = CW'(item_id_i) <= CW'(MAX_ITEMS);
  assign stat_o.rank_ok  = (rank_i != 9'd0) && (CW'(rank_i) <= CW'(lp_q));
  assign stat_o.found    = (LW'(cur_q) < lp_q) && (item_rdata_q == id_q);
  assign stat_o.cur_edge = ctl_i.up ? (cur_q == '0) : (LW'(cur_q) + LW'(1) == lp_q);
  assign stat_o.nb_edge  = ctl_i.up ? (nb == '0) : (LW'(nb) + LW'(1) == lp_q);

  // A load is taken only below the item limit and the shelf count, and for an id in range.
  assign load_fire = ctl_i.load && stat_o.id_ok && (lp_q < LW'(MAX_ITEMS))
                     && (CW'(lp_q) < CW'(shelf_q));

  // Item memory read address.
  always_comb begin
    rd_en = 1'b1;
    unique case (ctl_i.rd_sel)
      RD_RANK:   rd_addr = PW'(rank_i - 9'd1);
      RD_POS:    rd_addr = pos_rdata_q;
      RD_CUR_NB: rd_addr = nb;
      RD_NB_NB:  rd_addr = nb2;
      default: begin
        rd_addr = '0;
        rd_en   = 1'b0;
      end
    endcase
  end

  // Write ports of both memories.
  always_comb begin
    wr_en    = 1'b1;
    wr_addr  = cur_q;
    wr_data  = id_q;
    pwr_addr = IDX_W'(id_q);
    pwr_data = cur_q;
    if (load_fire) begin
      wr_addr  = PW'(lp_q);
      wr_data  = item_id_i;
      pwr_addr = IDX_W'(item_id_i);
      pwr_data = PW'(lp_q);
    end else if (ctl_i.step_wr) begin
      wr_data  = item_rdata_q;
      pwr_addr = IDX_W'(item_rdata_q);
    end else if (!ctl_i.final_wr) begin
      wr_en = 1'b0;
    end
    pwr_en = wr_en;
  end

  // Item memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      item_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      item_rdata_q <= item_mem[rd_addr];
    end
  end

  // Position memory.
  always_ff @(posedge clk_i) begin
    if (pwr_en) begin
      pos_mem[pwr_addr] <= pwr_data;
    end
    if (ctl_i.pos_rd) begin
      pos_rdata_q <= pos_mem[IDX_W'(item_id_i)];
    end
  end

  // Payload registers of the transaction in flight.
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      id_q <= item_id_i;
    end
    if (ctl_i.cur_load) begin
      cur_q <= pos_rdata_q;
    end else if (ctl_i.step_wr) begin
      cur_q <= nb;
    end
  end

  // Configuration, fill count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shelf_q <= SHELF_RESET;
      lp_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        shelf_q <= cfg_wdata_i;
      end
      if (load_fire) begin
        lp_q <= lp_q + LW'(1);
      end
      done_q <= (ctl_i.resp != RESP_NONE);
    end
  end

  // Result value.
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.resp)
      RESP_CUR:  answer_q <= 9'(cur_q);
      RESP_ITEM: answer_q <= item_rdata_q;
      default:   answer_q <= 9'd0;
    endcase
  end

  assign done_o   = done_q;
  assign answer_o = answer_q;

endmodule

`default_nettype wire

// ===== src/ordered_shelf_list_engine.sv =====
// Load, ask, query and unused commands do not walk the list; the result strobe on done_o is registered.
// Top and bottom walk until the chosen end of the list is reached; swap exchanges an item with one neighbour.
// The walk moves one entry per cycle through the item memory's single write port.
// A new command is taken only while busy is low; results cannot be stalled.
// Reset clears the fill count and sets shelf count to 256; list contents are not cleared.
`default_nettype none

module ordered_shelf_list_engine
  import osle_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [8:0] cfg_wdata_i,
  input  wire        start,
  output logic       busy,
  input  wire  [2:0] cmd_i,
  input  wire  [8:0] item_id_i,
  input  wire signed [1:0] direction_i,
  input  wire  [8:0] rank_i,
  output logic       done_o,
  output logic [8:0] answer_o
);

`include "ordered_shelf_list_engine_defines.svh"

  ctl_t  ctl;
  stat_t stat;

  // Sequencer.
  osle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .direction_i(direction_i),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .busy_o     (busy)
  );

  // Memories and registers.
  osle_dpath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_id_i  (item_id_i),
    .rank_i     (rank_i),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .done_o     (done_o),
    .answer_o   (answer_o)
  );

  // A load completes in the cycle it is taken.
  `OSLE_ASSERT_NEXT(a_load_single, start && !busy && cmd_i == CMD_LOAD, !busy, "load held busy")
  // Unused commands give no result.
  `OSLE_ASSERT_NEXT(a_nop_silent, start && !busy && cmd_i > CMD_QUERY, !done_o, "result from unused command")
  // A query for rank zero answers zero without a memory read.
  `OSLE_ASSERT_NEXT(a_rank_zero, start && !busy && cmd_i == CMD_QUERY && rank_i == 9'd0, done_o && answer_o == 9'd0, "rank zero not answered with zero")
  // A result always follows a transaction.
  `OSLE_ASSERT_NOW(a_done_cause, done_o, $past(busy) || $past(start), "result without a transaction")

endmodule

`default_nettype wire
